@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They sample on clk_i and are disabled
// while rst_ni is low, so a module that uses them must have both ports.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define RFAE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define RFAE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define RFAE_ASSERT(label, prop, msg)
`define RFAE_NEVER(label, cond, msg)

`endif

`endif

@@ design/rfae_pkg.sv @@
// ----------------------------------------------------------------------------
// Register file ALU executor package
// Instruction field positions, the decoded request type and the ALU function
// shared by the front and back parts.
// ----------------------------------------------------------------------------
package rfae_pkg;

  parameter int unsigned DataW    = 16;
  parameter int unsigned InstrW   = 16;
  parameter int unsigned RegCount = 8;
  parameter int unsigned RegIdxW  = $clog2(RegCount);
  parameter int unsigned AluOpW   = 3;

  // Instruction field positions (low bit of each field).
  parameter int unsigned FieldALsb  = 13;
  parameter int unsigned FieldBLsb  = 10;
  parameter int unsigned FieldOpLsb = 2;

  parameter logic [DataW-1:0] RegResetVal = 16'h1234;

  // Shift amounts at or above this limit give zero.
  parameter int unsigned ShiftLimit = 16;
  parameter int unsigned ShiftW     = $clog2(ShiftLimit);

  // Compare result codes.
  parameter logic [DataW-1:0] CmpEqual   = 16'd0;
  parameter logic [DataW-1:0] CmpGreater = 16'd1;
  parameter logic [DataW-1:0] CmpLess    = 16'd2;

  typedef enum logic [AluOpW-1:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_AND = 3'd2,
    ALU_OR  = 3'd3,
    ALU_XOR = 3'd4,
    ALU_SLL = 3'd5,
    ALU_SRL = 3'd6,
    ALU_CMP = 3'd7
  } alu_op_e;

  // One decoded request as it travels from the front to the back.
  typedef struct packed {
    logic [RegIdxW-1:0] a_idx;
    logic [RegIdxW-1:0] b_idx;
    alu_op_e            op;
  } uop_t;

  function automatic logic [DataW-1:0] alu_compute(alu_op_e op, logic [DataW-1:0] a,
                                                   logic [DataW-1:0] b);
    logic [DataW-1:0] res;
    logic             big_shift;
    big_shift = (b >= DataW'(ShiftLimit));
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      ALU_AND: res = a & b;
      ALU_OR:  res = a | b;
      ALU_XOR: res = a ^ b;
      ALU_SLL: res = big_shift ? '0 : (a << b[ShiftW-1:0]);
      ALU_SRL: res = big_shift ? '0 : (a >> b[ShiftW-1:0]);
      ALU_CMP: res = (a == b) ? CmpEqual : ((a > b) ? CmpGreater : CmpLess);
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

@@ design/rfae_front.sv @@
// ----------------------------------------------------------------------------
// Front part
// Accepts instruction words, decodes the register indexes and the ALU
// operation, and holds decoded requests in a short queue for the back part.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfae_front import rfae_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [InstrW-1:0] instruction_i,
  output logic              uop_valid_o,
  output uop_t              uop_o,
  input  logic              uop_pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  uop_t            queue_mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  uop_t            dec;
  logic            push;
  logic            pop;

  always_comb begin
    dec.a_idx = instruction_i[FieldALsb +: RegIdxW];
    dec.b_idx = instruction_i[FieldBLsb +: RegIdxW];
    dec.op    = alu_op_e'(instruction_i[FieldOpLsb +: AluOpW]);
  end

  assign in_stall_o  = (cnt_q == CntW'(QueueDepth));
  assign uop_valid_o = (cnt_q != '0);
  assign uop_o       = queue_mem[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = uop_pop_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[wr_ptr_q] <= dec;
    end
  end

  `RFAE_NEVER(a_cnt_over, cnt_q > CntW'(QueueDepth), "queue count exceeds depth")
  `RFAE_NEVER(a_pop_empty, pop && !uop_valid_o, "pop from empty queue")
  `RFAE_ASSERT(a_cnt_push, (push && !pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)), "count did not grow on push")

endmodule

@@ design/rfae_back.sv @@
// ----------------------------------------------------------------------------
// Back part
// Reads both operands from the register file, runs the ALU, writes the result
// back and presents it in an output register. A result written in one cycle
// is forwarded to a read of the same register in that cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfae_back import rfae_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               uop_valid_i,
  input  uop_t               uop_i,
  output logic               uop_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DataW-1:0]   result_value_o,
  output logic [RegIdxW-1:0] dest_index_o
);

  logic [DataW-1:0]   rf_mem_q [RegCount];
  logic [RegCount-1:0] rf_vld_q, rf_vld_d;

  logic               rd_valid_q, rd_valid_d;
  uop_t               rd_uop_q;
  logic [DataW-1:0]   rd_a_data_q;
  logic [DataW-1:0]   rd_b_data_q;

  logic               out_valid_q, out_valid_d;
  logic [DataW-1:0]   out_value_q;
  logic [RegIdxW-1:0] out_dest_q;

  logic               ex_fire;
  logic               rd_take;
  logic [DataW-1:0]   alu_res;

  assign ex_fire   = rd_valid_q && (!out_valid_q || !out_stall_i);
  assign rd_take   = uop_valid_i && (!rd_valid_q || ex_fire);
  assign uop_pop_o = rd_take;
  assign alu_res   = alu_compute(rd_uop_q.op, rd_a_data_q, rd_b_data_q);

  always_comb begin
    rd_valid_d  = rd_take ? 1'b1 : (ex_fire ? 1'b0 : rd_valid_q);
    out_valid_d = ex_fire ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
    rf_vld_d    = rf_vld_q;
    if (ex_fire) begin
      rf_vld_d[rd_uop_q.a_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rf_vld_q    <= '0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      rf_vld_q    <= rf_vld_d;
    end
  end

  // Register file write port and registered operand reads. An entry never
  // written since reset reads as the reset value.
  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      rf_mem_q[rd_uop_q.a_idx] <= alu_res;
      out_value_q              <= alu_res;
      out_dest_q               <= rd_uop_q.a_idx;
    end
    if (rd_take) begin
      rd_uop_q <= uop_i;
      if (ex_fire && (rd_uop_q.a_idx == uop_i.a_idx)) begin
        rd_a_data_q <= alu_res;
      end else if (!rf_vld_q[uop_i.a_idx]) begin
        rd_a_data_q <= RegResetVal;
      end else begin
        rd_a_data_q <= rf_mem_q[uop_i.a_idx];
      end
      if (ex_fire && (rd_uop_q.a_idx == uop_i.b_idx)) begin
        rd_b_data_q <= alu_res;
      end else if (!rf_vld_q[uop_i.b_idx]) begin
        rd_b_data_q <= RegResetVal;
      end else begin
        rd_b_data_q <= rf_mem_q[uop_i.b_idx];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign dest_index_o   = out_dest_q;

  `RFAE_ASSERT(a_fire_out, ex_fire |=> out_valid_q, "executed request produced no result")
  `RFAE_ASSERT(a_fire_dest, ex_fire |=> (out_dest_q == $past(rd_uop_q.a_idx)), "result index mismatch")
  `RFAE_ASSERT(a_cmp_range, (ex_fire && (rd_uop_q.op == ALU_CMP)) |=> (out_value_q <= CmpLess), "compare code out of range")
  `RFAE_NEVER(a_take_busy, rd_take && rd_valid_q && !ex_fire, "operand stage overwritten")

endmodule

@@ design/register_file_alu_executor_core.sv @@
// ----------------------------------------------------------------------------
// Register file ALU executor core
// Executes 16-bit instruction words against eight 16-bit registers and
// returns the new destination value with its register index.
// ----------------------------------------------------------------------------
// Path: with nothing queued, a result becomes valid once its instruction has
// passed the registered queue write, operand read, and ALU and write back.
// Throughput: one instruction per cycle unless out_stall_i holds it; the
// operand read to write back loop is closed by forwarding the ALU result.
// Reset: every register reads as 0x1234 right after reset (per-register valid
// flags), and the queue and pipeline are emptied. QueueDepth must be 2 or more.

module register_file_alu_executor_core import rfae_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [InstrW-1:0]  instruction_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DataW-1:0]   result_value_o,
  output logic [RegIdxW-1:0] dest_index_o
);

  logic uop_valid;
  uop_t uop;
  logic uop_pop;

  rfae_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .instruction_i(instruction_i),
    .uop_valid_o  (uop_valid),
    .uop_o        (uop),
    .uop_pop_i    (uop_pop)
  );

  rfae_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .uop_valid_i   (uop_valid),
    .uop_i         (uop),
    .uop_pop_o     (uop_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o),
    .dest_index_o  (dest_index_o)
  );

endmodule

@@ sim/tb_register_file_alu_executor_core.sv @@
// ----------------------------------------------------------------------------
// Register file ALU executor core testbench
// Sends instruction words through the request channel and keeps a shadow
// register file that predicts every write back. Each returned value and
// register index is compared in order with the prediction. Both channels
// idle at random, the mix changes between phases, and one pause lets the
// core drain completely.
// ----------------------------------------------------------------------------
module tb_register_file_alu_executor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rfae_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]   value;
    logic [RegIdxW-1:0] idx;
  } writeback_t;

  class rf_shadow;
    logic [DataW-1:0] regs [RegCount];
    writeback_t       pending_writebacks[$];
    int unsigned      mismatches;

    function new();
      foreach (regs[i]) regs[i] = RegResetVal;
      mismatches = 0;
    endfunction

    function automatic logic [DataW-1:0] alu_result(alu_op_e op, logic [DataW-1:0] a,
                                                    logic [DataW-1:0] b);
      case (op)
        ALU_ADD: return a + b;
        ALU_SUB: return a - b;
        ALU_AND: return a & b;
        ALU_OR:  return a | b;
        ALU_XOR: return a ^ b;
        ALU_SLL: return (b < ShiftLimit) ? DataW'(a << b) : '0;
        ALU_SRL: return (b < ShiftLimit) ? DataW'(a >> b) : '0;
        default: return (a == b) ? CmpEqual : ((a > b) ? CmpGreater : CmpLess);
      endcase
    endfunction

    // Both operands are read before the write back, so A == B sees the old value.
    function void note_instruction(logic [InstrW-1:0] word);
      logic [RegIdxW-1:0] a_idx;
      logic [RegIdxW-1:0] b_idx;
      alu_op_e            op;
      writeback_t         wb;
      a_idx    = word[FieldALsb +: RegIdxW];
      b_idx    = word[FieldBLsb +: RegIdxW];
      op       = alu_op_e'(word[FieldOpLsb +: AluOpW]);
      wb.value = alu_result(op, regs[a_idx], regs[b_idx]);
      wb.idx   = a_idx;
      regs[a_idx] = wb.value;
      pending_writebacks.insert(pending_writebacks.size(), wb);
    endfunction

    function void check_writeback(logic [DataW-1:0] value, logic [RegIdxW-1:0] idx);
      writeback_t exp_wb;
      if (pending_writebacks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: value %h index %0d", value, idx);
        return;
      end
      exp_wb = pending_writebacks.pop_front();
      if (value !== exp_wb.value || idx !== exp_wb.idx) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected value %h index %0d, got value %h index %0d",
                   exp_wb.value, exp_wb.idx, value, idx);
      end
    endfunction

    function int unsigned outstanding();
      return pending_writebacks.size();
    endfunction

    // Returns a register holding a small value, or -1 if there is none.
    function int small_reg();
      int hits[$];
      foreach (regs[i]) if (regs[i] <= 20) hits.insert(hits.size(), i);
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1)];
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [InstrW-1:0]  instruction_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [DataW-1:0]   result_value_o;
  logic [RegIdxW-1:0] dest_index_o;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 54;
  rf_shadow    shadow = new();

  register_file_alu_executor_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .instruction_i  (instruction_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .dest_index_o   (dest_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      shadow.check_writeback(result_value_o, dest_index_o);
  end

  // Unused bits [9:5] and [1:0] get random values.
  function automatic logic [InstrW-1:0] encode(int unsigned a, int unsigned b, alu_op_e op);
    logic [InstrW-1:0] word;
    word = InstrW'($urandom);
    word[FieldALsb +: RegIdxW]  = RegIdxW'(a);
    word[FieldBLsb +: RegIdxW]  = RegIdxW'(b);
    word[FieldOpLsb +: AluOpW]  = op;
    return word;
  endfunction

  task automatic send_request(logic [InstrW-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    instruction_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.note_instruction(word);
  endtask

  task automatic send_random_request();
    int unsigned a;
    int unsigned b;
    int          low_reg;
    bit          shift_op;
    alu_op_e     op;
    if ($urandom_range(19) == 0) begin
      send_request(InstrW'($urandom));
      return;
    end
    op = alu_op_e'($urandom_range(7));
    a  = $urandom_range(RegCount - 1);
    b  = $urandom_range(RegCount - 1);
    shift_op = (op == ALU_SLL) || (op == ALU_SRL);
    // Small second operands make the shift amounts straddle the limit.
    if ($urandom_range(shift_op ? 1 : 3) == 0) begin
      low_reg = shadow.small_reg();
      if (low_reg >= 0) b = low_reg;
    end
    send_request(encode(a, b, op));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    instruction_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Build small values with compares, then walk the shift limit.
    send_request(encode(1, 1, ALU_SUB));   // r1 = 0
    send_request(encode(2, 1, ALU_CMP));   // greater: r2 = 1
    send_request(encode(1, 2, ALU_CMP));   // less: r1 = 2
    send_request(encode(0, 0, ALU_CMP));   // same register: equal
    send_request(encode(0, 2, ALU_SUB));   // wraps to 0xFFFF
    send_request(encode(1, 1, ALU_ADD));   // 4
    send_request(encode(1, 1, ALU_ADD));   // 8
    send_request(encode(1, 1, ALU_ADD));   // 16
    send_request(encode(3, 1, ALU_SLL));   // shift by exactly 16
    send_request(encode(4, 1, ALU_SRL));
    send_request(encode(1, 2, ALU_SUB));   // 15
    send_request(encode(0, 1, ALU_SLL));   // shift by 15
    send_request(encode(0, 1, ALU_SRL));
    send_request(encode(7, 7, ALU_SUB));
    send_request(encode(7, 2, ALU_SUB));
    send_request(encode(7, 7, ALU_ADD));   // add wraps
    send_request(encode(6, 7, ALU_AND));
    send_request(encode(5, 7, ALU_OR));
    send_request(encode(5, 5, ALU_XOR));
    send_request(encode(6, 7, ALU_SRL));   // shift by 0xFFFE
    send_request(16'hFFFF);
    send_request(16'h0000);

    repeat (340) send_random_request();
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 34;
    repeat (340) send_random_request();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (340) send_random_request();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0)
      $display("tb_register_file_alu_executor_core: PASS");
    else
      $display("tb_register_file_alu_executor_core: FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_register_file_alu_executor_core: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/rfae_pkg.sv
design/rfae_front.sv
design/rfae_back.sv
design/register_file_alu_executor_core.sv
sim/tb_register_file_alu_executor_core.sv
